/* src/ncs_pkg.sv */
// ncs_pkg: shared types, constants and helpers for the cubic spline interpolator
// no dependencies; imported by ncs_div and natural_cubic_spline_interp

package ncs_pkg;

   // grid size and derived counts
   localparam int NODES = 5;
   localparam int IW    = $clog2(NODES);
   localparam int LAST  = NODES - 1;
   localparam int NSYS  = NODES - 2;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // divider widths
   localparam int DNW = 64;
   localparam int DDW = 33;

   typedef struct packed {
      logic              op;
      logic [3:0]        node_index;
      logic signed [23:0] node_value;
      logic [19:0]       point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clamped;
   } rsp_type;

   // divider control towards the shared unit
   typedef struct packed {
      logic signed [DNW-1:0] num;
      logic [DDW-1:0]        den;
      logic                  floor_mode;
   } div_req_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic signed [DNW-1:0] quot;
   } div_rsp_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* src/ncs_div.sv */
// ncs_div: shared restoring divider, one quotient bit per cycle
// signed dividend over positive divisor, truncating or flooring; uses ncs_pkg

module ncs_div
   import ncs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic           run_ff, run_in;
   logic           fin_ff, fin_in;
   logic           done_ff, done_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [DNW-1:0] dvd_ff, dvd_in;
   logic [DDW-1:0] rem_ff, rem_in;
   logic [DDW-1:0] den_ff, den_in;
   logic           neg_ff, neg_in;
   logic           floor_ff, floor_in;
   logic signed [DNW-1:0] quot_ff, quot_in;

   logic [DDW:0]   rem_sh;
   logic [DDW:0]   diff;

   // one restoring step
   assign rem_sh = {rem_ff, dvd_ff[DNW-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      run_in   = run_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      floor_in = floor_ff;
      quot_in  = quot_ff;
      if (start && !run_ff && !fin_ff) begin
         // load magnitude of the dividend
         neg_in   = div_req.num[DNW-1];
         dvd_in   = div_req.num[DNW-1] ? DNW'(-div_req.num) : DNW'(div_req.num);
         rem_in   = '0;
         den_in   = div_req.den;
         floor_in = div_req.floor_mode;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         if (!diff[DDW]) begin
            rem_in = diff[DDW-1:0];
            dvd_in = {dvd_ff[DNW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DDW-1:0];
            dvd_in = {dvd_ff[DNW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         // restore the sign, rounding down for floor mode
         if (neg_ff) begin
            if (floor_ff && (rem_ff != '0)) begin
               quot_in = -$signed(dvd_ff + DNW'(1));
            end else begin
               quot_in = -$signed(dvd_ff);
            end
         end else begin
            quot_in = $signed(dvd_ff);
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      floor_ff <= floor_in;
      quot_ff  <= quot_in;
   end

   assign div_rsp.busy = run_ff | fin_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

/* src/natural_cubic_spline_interp.sv */
// Natural cubic spline on a unit grid of NODES values. A write item (op low) stores one
// node value and gives no result; an index beyond the grid is ignored. An
// evaluate item gives one result, strobed on rsp_strobe for a single cycle with no way
// for the receiver to hold it off, and busy stays high until that strobe. A query at or
// beyond the last node returns that node with clamped set. Any other query keeps busy
// high through the chain of products on the shared multiplier: four for the cubes, four
// for the terms and two for the floor divide by six by reciprocal. After writes the
// first evaluate re-solves the second derivatives first: two divides per inner node on
// the shared divider, then one multiply per back substitution step.
// depends on ncs_pkg and ncs_div

module natural_cubic_spline_interp
   import ncs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_F_R0  = 5'd1;
   localparam logic [4:0] S_F_R1  = 5'd2;
   localparam logic [4:0] S_F_R2  = 5'd3;
   localparam logic [4:0] S_F_D1  = 5'd4;
   localparam logic [4:0] S_F_W1  = 5'd5;
   localparam logic [4:0] S_F_W2  = 5'd6;
   localparam logic [4:0] S_B_MUL = 5'd7;
   localparam logic [4:0] S_B_WR  = 5'd8;
   localparam logic [4:0] S_E_CHK = 5'd9;
   localparam logic [4:0] S_E_UU  = 5'd10;
   localparam logic [4:0] S_E_UUU = 5'd11;
   localparam logic [4:0] S_E_TT  = 5'd12;
   localparam logic [4:0] S_E_TTT = 5'd13;
   localparam logic [4:0] S_E_A   = 5'd14;
   localparam logic [4:0] S_E_B   = 5'd15;
   localparam logic [4:0] S_E_C   = 5'd16;
   localparam logic [4:0] S_E_D   = 5'd17;
   localparam logic [4:0] S_E_F   = 5'd18;
   localparam logic [4:0] S_E_G   = 5'd19;
   localparam logic [4:0] S_E_H   = 5'd20;
   localparam logic [4:0] S_E_I   = 5'd21;
   localparam logic [4:0] S_E_J   = 5'd22;

   localparam logic [DDW-1:0] DEN0     = DDW'(64'h1_0000_0000);
   localparam logic [19:0]    CLAMP_PT = 20'(LAST) << 16;

   // divide by six: bias to a positive value, halve, then divide by three
   localparam logic signed [63:0] DIV6_BIAS   = 64'sd12884901888;
   localparam logic signed [63:0] DIV6_UNBIAS = 64'sd4294967296;
   localparam logic [34:0]        THIRD_HI    = 35'd21845;
   localparam logic [34:0]        THIRD_RCP   = 35'd1431655766;

   logic [4:0]  state_ff, state_in;
   logic        stale_ff, stale_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [3:0]  seg_ff, seg_in;
   logic [15:0] t_ff, t_in;
   logic [16:0] u_ff, u_in;
   logic [16:0] u3_ff, u3_in;
   logic [16:0] t3_ff, t3_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [DDW-1:0] den_ff, den_in;
   logic signed [31:0] prev_s_ff, prev_s_in;
   logic [30:0] cur_ratio_ff, cur_ratio_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_ff, rsp_in;

   logic signed [23:0] node_ff [NODES];
   logic signed [23:0] node_in [NODES];
   logic signed [31:0] m_ff [NODES];
   logic signed [31:0] m_in [NODES];
   logic signed [31:0] scr_ff [NODES];
   logic signed [31:0] scr_in [NODES];
   logic [30:0] ratio_ff [NODES];
   logic [30:0] ratio_in [NODES];

   logic [IW-1:0] nd_addr, m_addr;
   logic signed [23:0] node_rd;
   logic signed [31:0] m_rd;
   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] mul_p;
   logic signed [34:0] node6;
   logic signed [63:0] corr;
   logic        div_start;
   div_req_type div_req;
   div_rsp_type div_rsp;

   ncs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // read port addresses
   always_comb begin
      unique case (state_ff)
         S_F_R1:          nd_addr = i_ff + IW'(1);
         S_F_R2:          nd_addr = i_ff + IW'(2);
         S_E_C:           nd_addr = seg_ff[IW-1:0];
         S_E_D:           nd_addr = seg_ff[IW-1:0] + IW'(1);
         S_E_CHK:         nd_addr = IW'(LAST);
         default:         nd_addr = i_ff;
      endcase
      unique case (state_ff)
         S_E_B, S_E_D:    m_addr = seg_ff[IW-1:0] + IW'(1);
         S_B_MUL:         m_addr = j_ff + IW'(1);
         default:         m_addr = seg_ff[IW-1:0];
      endcase
   end

   assign node_rd = node_ff[nd_addr];
   assign m_rd    = m_ff[m_addr];
   assign node6   = (35'(node_rd) <<< 2) + (35'(node_rd) <<< 1);

   // shared multiplier operand selection
   always_comb begin
      unique case (state_ff)
         S_E_UU: begin
            mul_a = 35'(u_ff);
            mul_b = 35'(u_ff);
         end
         S_E_UUU: begin
            mul_a = 35'(prod_ff[32:0]);
            mul_b = 35'(u_ff);
         end
         S_E_TT: begin
            mul_a = 35'(t_ff);
            mul_b = 35'(t_ff);
         end
         S_E_TTT: begin
            mul_a = 35'(prod_ff[32:0]);
            mul_b = 35'(t_ff);
         end
         S_E_A: begin
            mul_a = 35'(m_rd);
            mul_b = 35'(u3_ff);
         end
         S_E_B: begin
            mul_a = 35'(m_rd);
            mul_b = 35'(t3_ff);
         end
         S_E_C: begin
            mul_a = node6 - 35'(m_rd);
            mul_b = 35'(u_ff);
         end
         S_E_D: begin
            mul_a = node6 - 35'(m_rd);
            mul_b = 35'(t_ff);
         end
         S_E_H: begin
            mul_a = 35'(acc_ff[33:16]);
            mul_b = THIRD_HI;
         end
         S_E_I: begin
            mul_a = 35'(acc_ff[33:16]) + 35'(acc_ff[15:0]);
            mul_b = THIRD_RCP;
         end
         S_B_MUL: begin
            mul_a = 35'(ratio_ff[j_ff - IW'(1)]);
            mul_b = 35'(m_rd);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign corr  = (prod_ff + 64'sd536870912) >>> 30;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      stale_in      = stale_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      seg_in        = seg_ff;
      t_in          = t_ff;
      u_in          = u_ff;
      u3_in         = u3_ff;
      t3_in         = t3_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      prev_s_in     = prev_s_ff;
      cur_ratio_in  = cur_ratio_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      node_in       = node_ff;
      m_in          = m_ff;
      scr_in        = scr_ff;
      ratio_in      = ratio_ff;
      div_start     = 1'b0;
      div_req.num   = '0;
      div_req.den   = den_ff;
      div_req.floor_mode = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.op == OP_WRITE) begin
                  if ({1'b0, req_data.node_index} < 5'(NODES)) begin
                     node_in[req_data.node_index[IW-1:0]] = req_data.node_value;
                     stale_in = 1'b1;
                  end
               end else begin
                  seg_in = req_data.point[19:16];
                  t_in   = req_data.point[15:0];
                  u_in   = 17'h10000 - 17'(req_data.point[15:0]);
                  if (stale_ff) begin
                     i_in      = '0;
                     den_in    = DEN0;
                     prev_s_in = '0;
                     state_in  = S_F_R0;
                  end else begin
                     state_in = S_E_CHK;
                  end
               end
            end
         end
         // second difference of three neighbouring nodes
         S_F_R0: begin
            acc_in   = 64'(node_rd);
            state_in = S_F_R1;
         end
         S_F_R1: begin
            acc_in   = acc_ff - (64'(node_rd) <<< 1);
            state_in = S_F_R2;
         end
         S_F_R2: begin
            acc_in   = acc_ff + 64'(node_rd);
            state_in = S_F_D1;
         end
         // sweep ratio
         S_F_D1: begin
            div_start   = 1'b1;
            div_req.num = 64'sh1000_0000_0000_0000;
            state_in    = S_F_W1;
         end
         // forward right side
         S_F_W1: begin
            if (div_rsp.done) begin
               cur_ratio_in     = div_rsp.quot[30:0];
               ratio_in[i_ff]   = div_rsp.quot[30:0];
               div_start        = 1'b1;
               div_req.num      = (((acc_ff <<< 2) + (acc_ff <<< 1)) - 64'(prev_s_ff)) <<< 30;
               state_in         = S_F_W2;
            end
         end
         S_F_W2: begin
            if (div_rsp.done) begin
               scr_in[i_ff] = sat32(div_rsp.quot);
               prev_s_in    = sat32(div_rsp.quot);
               if (i_ff == IW'(NSYS - 1)) begin
                  m_in[IW'(NSYS)] = sat32(div_rsp.quot);
                  if (NSYS >= 2) begin
                     j_in     = IW'(NSYS - 1);
                     state_in = S_B_MUL;
                  end else begin
                     stale_in = 1'b0;
                     state_in = S_E_CHK;
                  end
               end else begin
                  i_in     = i_ff + IW'(1);
                  den_in   = DEN0 - DDW'(cur_ratio_ff);
                  state_in = S_F_R0;
               end
            end
         end
         // back substitution
         S_B_MUL: begin
            prod_in  = mul_p[63:0];
            state_in = S_B_WR;
         end
         S_B_WR: begin
            m_in[j_ff] = sat32(64'(scr_ff[j_ff - IW'(1)]) - corr);
            if (j_ff == IW'(1)) begin
               stale_in = 1'b0;
               state_in = S_E_CHK;
            end else begin
               j_in     = j_ff - IW'(1);
               state_in = S_B_MUL;
            end
         end
         // clamp check
         S_E_CHK: begin
            if ({seg_ff, t_ff} >= CLAMP_PT) begin
               rsp_in.value   = 32'(node_rd);
               rsp_in.clamped = 1'b1;
               rsp_strobe_in  = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_E_UU;
            end
         end
         // cubes of the weights
         S_E_UU: begin
            prod_in  = mul_p[63:0];
            state_in = S_E_UUU;
         end
         S_E_UUU: begin
            prod_in  = mul_p[63:0];
            state_in = S_E_TT;
         end
         S_E_TT: begin
            u3_in    = prod_ff[48:32];
            prod_in  = mul_p[63:0];
            state_in = S_E_TTT;
         end
         S_E_TTT: begin
            prod_in  = mul_p[63:0];
            state_in = S_E_A;
         end
         // accumulate the four terms
         S_E_A: begin
            t3_in    = prod_ff[48:32];
            prod_in  = mul_p[63:0];
            state_in = S_E_B;
         end
         S_E_B: begin
            acc_in   = prod_ff;
            prod_in  = mul_p[63:0];
            state_in = S_E_C;
         end
         S_E_C: begin
            acc_in   = acc_ff + prod_ff;
            prod_in  = mul_p[63:0];
            state_in = S_E_D;
         end
         S_E_D: begin
            acc_in   = acc_ff + prod_ff;
            prod_in  = mul_p[63:0];
            state_in = S_E_F;
         end
         S_E_F: begin
            acc_in   = acc_ff + prod_ff;
            state_in = S_E_G;
         end
         // floor divide by six: round, halve and bias to a positive value
         S_E_G: begin
            acc_in   = ((acc_ff + 64'sd196608) >>> 17) + DIV6_BIAS;
            state_in = S_E_H;
         end
         // divide by three: upper half times a third of 2^16, then the remainder
         S_E_H: begin
            prod_in  = mul_p[63:0];
            state_in = S_E_I;
         end
         S_E_I: begin
            acc_in   = prod_ff;
            prod_in  = mul_p[63:0];
            state_in = S_E_J;
         end
         S_E_J: begin
            rsp_in.value   = sat32(acc_ff + (prod_ff >>> 32) - DIV6_UNBIAS);
            rsp_in.clamped = 1'b0;
            rsp_strobe_in  = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stale_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int k = 0; k < NODES; k++) begin
            node_ff[k] <= '0;
            m_ff[k]    <= '0;
         end
      end else begin
         state_ff      <= state_in;
         stale_ff      <= stale_in;
         rsp_strobe_ff <= rsp_strobe_in;
         node_ff       <= node_in;
         m_ff          <= m_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      seg_ff       <= seg_in;
      t_ff         <= t_in;
      u_ff         <= u_in;
      u3_ff        <= u3_in;
      t3_ff        <= t3_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      den_ff       <= den_in;
      prev_s_ff    <= prev_s_in;
      cur_ratio_ff <= cur_ratio_in;
      rsp_ff       <= rsp_in;
      scr_ff       <= scr_in;
      ratio_ff     <= ratio_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a write transfer never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_WRITE) |=> !rsp_strobe_ff)
      else $error("result after write transfer");

   // divider only started when free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // evaluation only runs on a solved table
   a_solved: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_E_CHK) |-> !stale_ff)
      else $error("evaluation on stale table");

   // result strobe only as the sequencer returns idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while busy");

endmodule
